// ===== src/ptpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Point-to-point mover package
// Shared constants, CORDIC arc table and command codes.
// ----------------------------------------------------------------------------
package ptpm_pkg;

   localparam int CordicSteps = 16;
   localparam int StepCntW    = $clog2(CordicSteps + 1);

   // Working width of the CORDIC datapath: offsets reach 33 bits, gain 1.65
   // and the half-turn pre-rotation add a couple more.
   localparam int DataW = 36;

   localparam logic [31:0] InvGain     = 32'h9B74_EDA8;
   localparam logic [31:0] HalfTurn    = 32'h8000_0000;
   localparam logic [31:0] QuarterTurn = 32'h4000_0000;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_MOVE  = 2'd1;
   localparam logic [1:0] KIND_STOP  = 2'd2;
   localparam logic [1:0] KIND_PLACE = 2'd3;

   typedef struct packed {
      logic                 start;
      logic                 vectoring;
      logic signed [DataW-1:0] x0;
      logic signed [DataW-1:0] y0;
      logic [31:0]          z0;
   } cordic_cmd_type;

   typedef struct packed {
      logic                 done;
      logic signed [DataW-1:0] x;
      logic signed [DataW-1:0] y;
      logic [31:0]          z;
   } cordic_res_type;

   function automatic logic [31:0] arc_angle(input logic [4:0] idx);
      logic [31:0] a;
      case (idx)
         5'd0:  a = 32'd536870912;
         5'd1:  a = 32'd316933406;
         5'd2:  a = 32'd167458907;
         5'd3:  a = 32'd85004756;
         5'd4:  a = 32'd42667331;
         5'd5:  a = 32'd21354465;
         5'd6:  a = 32'd10679838;
         5'd7:  a = 32'd5340245;
         5'd8:  a = 32'd2670163;
         5'd9:  a = 32'd1335087;
         5'd10: a = 32'd667544;
         5'd11: a = 32'd333772;
         5'd12: a = 32'd166886;
         5'd13: a = 32'd83443;
         5'd14: a = 32'd41722;
         5'd15: a = 32'd20861;
         5'd16: a = 32'd10430;
         5'd17: a = 32'd5215;
         5'd18: a = 32'd2608;
         5'd19: a = 32'd1304;
         5'd20: a = 32'd652;
         5'd21: a = 32'd326;
         5'd22: a = 32'd163;
         5'd23: a = 32'd81;
         5'd24: a = 32'd41;
         5'd25: a = 32'd20;
         5'd26: a = 32'd10;
         5'd27: a = 32'd5;
         5'd28: a = 32'd3;
         5'd29: a = 32'd1;
         5'd30: a = 32'd1;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

endpackage

// ===== src/ptpm_ifs.sv =====
// ----------------------------------------------------------------------------
// Point-to-point mover channel interfaces
// Valid/ready channels for requests, responses and the speed register.
// ----------------------------------------------------------------------------
interface ptpm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [15:0]        elapsed_ms;
   logic signed [31:0] target_x;
   logic signed [31:0] target_y;
   modport source (output valid, kind, elapsed_ms, target_x, target_y, input ready);
   modport sink   (input valid, kind, elapsed_ms, target_x, target_y, output ready);
endinterface

interface ptpm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] now_x;
   logic signed [31:0] now_y;
   logic [15:0]        heading_out;
   logic               moving;
   modport source (output valid, now_x, now_y, heading_out, moving, input ready);
   modport sink   (input valid, now_x, now_y, heading_out, moving, output ready);
endinterface

interface ptpm_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] move_speed;
   modport source (output valid, move_speed, input ready);
   modport sink   (input valid, move_speed, output ready);
endinterface

// ===== src/ptpm_cordic.sv =====
// ----------------------------------------------------------------------------
// Point-to-point mover CORDIC unit
// One shared micro-rotation stage, iterated once per cycle for a full pass.
// ----------------------------------------------------------------------------
module ptpm_cordic
   import ptpm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cordic_cmd_type cmd,
   output cordic_res_type res
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic                    vec_ff, vec_in;
   logic [StepCntW-1:0]     cnt_ff, cnt_in;
   logic signed [DataW-1:0] x_ff, x_in, y_ff, y_in;
   logic [31:0]             z_ff, z_in;
   logic signed [DataW-1:0] xs, ys;
   logic                    dir_pos;
   logic [31:0]             arc;

   // Arithmetic shifts floor negative values, as required.
   assign xs  = x_ff >>> cnt_ff;
   assign ys  = y_ff >>> cnt_ff;
   assign arc = arc_angle(5'(cnt_ff));
   assign dir_pos = vec_ff ? (y_ff > 0) : !z_ff[31];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      vec_in  = vec_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         vec_in  = cmd.vectoring;
         cnt_in  = '0;
         x_in    = cmd.x0;
         y_in    = cmd.y0;
         z_in    = cmd.z0;
      end else if (busy_ff) begin
         if (vec_ff) begin
            if (dir_pos) begin
               x_in = x_ff + ys;  y_in = y_ff - xs;  z_in = z_ff + arc;
            end else begin
               x_in = x_ff - ys;  y_in = y_ff + xs;  z_in = z_ff - arc;
            end
         end else begin
            if (dir_pos) begin
               x_in = x_ff - ys;  y_in = y_ff + xs;  z_in = z_ff - arc;
            end else begin
               x_in = x_ff + ys;  y_in = y_ff - xs;  z_in = z_ff + arc;
            end
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == StepCntW'(CordicSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      vec_ff <= vec_in;
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   assign res.done = done_ff;
   assign res.x    = x_ff;
   assign res.y    = y_ff;
   assign res.z    = z_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("cordic done without a pass");
   a_no_done_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("cordic done while still busy");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff < StepCntW'(CordicSteps)) else $error("cordic count overrun");

endmodule

// ===== src/ptpm_mul.sv =====
// ----------------------------------------------------------------------------
// Point-to-point mover multiplier
// Registered 32 x 32 unsigned multiply, shared by step length and gain scaling.
// ----------------------------------------------------------------------------
module ptpm_mul
   import ptpm_pkg::*;
(
   input  logic        clock,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [63:0] p
);

   logic [63:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= 64'(a) * 64'(b);
   end

   assign p = p_ff;

endmodule

// ===== src/point_to_point_mover_top.sv =====
// ----------------------------------------------------------------------------
// Point-to-point mover
// Moves a Q16.16 position toward a goal at a programmable constant speed.
// ----------------------------------------------------------------------------
// Every request returns one response. Stop, place and a tick while stopped go
// straight to the response; a move makes one vectoring pass (none when the
// target equals the position), a tick that reaches the goal a vectoring pass,
// and a tick that advances a vectoring and a rotation pass. The time taken is
// set by the single CORDIC stage, which is iterated for each pass, and by the
// one shared 32 x 32 multiplier that forms the step length and scales by the
// CORDIC gain.
// The block takes no request until the response of the previous one has been
// transferred; move_speed may be written whenever the block is idle.
module point_to_point_mover_top
   import ptpm_pkg::*;
(
   input  logic clock,
   input  logic reset,
   ptpm_req_if.sink   req,
   ptpm_rsp_if.source rsp,
   ptpm_csr_if.sink   csr
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_STEP  = 4'd1;  // multiply speed by elapsed
   localparam logic [3:0] ST_VEC   = 4'd2;  // start vectoring pass
   localparam logic [3:0] ST_VWAIT = 4'd3;
   localparam logic [3:0] ST_MAGLO = 4'd4;  // magnitude low half times 1/K
   localparam logic [3:0] ST_MAGHI = 4'd5;
   localparam logic [3:0] ST_CMP   = 4'd6;
   localparam logic [3:0] ST_RWAIT = 4'd7;
   localparam logic [3:0] ST_SX    = 4'd8;  // scale x magnitude
   localparam logic [3:0] ST_SY    = 4'd9;  // scale y magnitude
   localparam logic [3:0] ST_ADD   = 4'd10;
   localparam logic [3:0] ST_RESP  = 4'd11;
   localparam logic [3:0] ST_MWAIT = 4'd12;

   logic [3:0]  st_ff, st_in;
   logic [31:0] speed_ff;
   logic signed [31:0] px_ff, px_in, py_ff, py_in, gx_ff, gx_in, gy_ff, gy_in;
   logic [15:0] hd_ff, hd_in;
   logic        act_ff, act_in;
   logic        is_move_ff, is_move_in;
   logic [15:0] ms_ff, ms_in;
   logic [31:0] step_ff, step_in;
   logic [33:0] mag_ff, mag_in;       // magnitude being scaled (below 2^34)
   logic [33:0] acc_ff, acc_in;       // scaled result accumulator
   logic        sgn_ff, sgn_in;
   logic signed [33:0] ax_ff, ax_in;
   logic        sel_hi_ff, sel_hi_in; // set while scaling rotation outputs, clear for the magnitude

   cordic_cmd_type cmd;
   cordic_res_type cres;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;

   ptpm_cordic u_cordic (.clock(clock), .reset(reset), .cmd(cmd), .res(cres));
   ptpm_mul    u_mul    (.clock(clock), .a(mul_a), .b(mul_b), .p(mul_p));

   logic signed [DataW-1:0] dx, dy, vx0, vy0;
   logic [31:0] vz0, rz;
   logic signed [DataW-1:0] rx0;
   logic [DataW-1:0] xabs;
   logic signed [34:0] sum;
   logic signed [31:0] sat;

   always_comb begin
      dx  = DataW'(gx_ff) - DataW'(px_ff);
      dy  = DataW'(gy_ff) - DataW'(py_ff);
      vx0 = dx[DataW-1] ? -dx : dx;
      vy0 = dx[DataW-1] ? -dy : dy;
      vz0 = dx[DataW-1] ? HalfTurn : 32'd0;
      rz  = {hd_ff, 16'd0};
      rx0 = DataW'({1'b0, step_ff});
      if (rz >= QuarterTurn && rz < (QuarterTurn + HalfTurn)) begin
         rx0 = -rx0;
         rz  = rz - HalfTurn;
      end
      xabs = cres.x[DataW-1] ? DataW'(-cres.x) : DataW'(cres.x);
   end

   always_comb begin
      st_in = st_ff;
      px_in = px_ff; py_in = py_ff; gx_in = gx_ff; gy_in = gy_ff;
      hd_in = hd_ff; act_in = act_ff; is_move_in = is_move_ff; ms_in = ms_ff;
      step_in = step_ff; mag_in = mag_ff; acc_in = acc_ff; sgn_in = sgn_ff;
      ax_in = ax_ff; sel_hi_in = sel_hi_ff;
      cmd = '0;
      mul_a = mag_ff[31:0];
      mul_b = InvGain;
      sum = '0;
      sat = '0;
      case (st_ff)
         ST_IDLE: begin
            if (req.valid) begin
               ms_in = req.elapsed_ms;
               case (req.kind)
                  KIND_TICK: begin
                     is_move_in = 1'b0;
                     st_in = act_ff ? ST_STEP : ST_RESP;
                  end
                  KIND_MOVE: begin
                     gx_in = req.target_x; gy_in = req.target_y;
                     act_in = 1'b1; is_move_in = 1'b1;
                     st_in = ST_VEC;
                  end
                  KIND_STOP: begin
                     act_in = 1'b0; st_in = ST_RESP;
                  end
                  default: begin
                     px_in = req.target_x; py_in = req.target_y;
                     gx_in = req.target_x; gy_in = req.target_y;
                     act_in = 1'b0; st_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_STEP: begin
            mul_a = speed_ff; mul_b = {16'd0, ms_ff};
            st_in = ST_MWAIT;
         end
         ST_MWAIT: begin
            step_in = (mul_p[63:32] != 32'd0) ? 32'hFFFF_FFFF : mul_p[31:0];
            st_in = ST_VEC;
         end
         ST_VEC: begin
            if (is_move_ff && dx == '0 && dy == '0) begin
               hd_in = 16'd0; st_in = ST_RESP;
            end else begin
               cmd.start = 1'b1; cmd.vectoring = 1'b1;
               cmd.x0 = vx0; cmd.y0 = vy0; cmd.z0 = vz0;
               st_in = ST_VWAIT;
            end
         end
         ST_VWAIT: begin
            if (cres.done) begin
               if (is_move_ff) begin
                  hd_in = 16'((cres.z + 32'h8000) >> 16);
                  st_in = ST_RESP;
               end else begin
                  mag_in = xabs[33:0]; sel_hi_in = 1'b0;
                  st_in = ST_MAGLO;
               end
            end
         end
         ST_MAGLO: begin
            // low half first; its product is ready in the next cycle
            mul_a = mag_ff[31:0];
            st_in = ST_MAGHI;
         end
         ST_MAGHI: begin
            mul_a = {30'd0, mag_ff[33:32]};
            acc_in = 34'(mul_p[63:32]);
            st_in = sel_hi_ff ? ST_ADD : ST_CMP;
         end
         ST_CMP: begin
            // acc holds floor(lo*k/2^32); add hi*k now on the multiplier output
            acc_in = acc_ff + mul_p[33:0];
            if (acc_ff + mul_p[33:0] <= {2'b0, step_ff}) begin
               px_in = gx_ff; py_in = gy_ff; act_in = 1'b0;
               st_in = ST_RESP;
            end else begin
               cmd.start = 1'b1; cmd.vectoring = 1'b0;
               cmd.x0 = rx0; cmd.y0 = '0; cmd.z0 = rz;
               st_in = ST_RWAIT;
            end
         end
         ST_RWAIT: begin
            if (cres.done) begin
               mag_in = cres.x[DataW-1] ? 34'(-cres.x) : 34'(cres.x);
               sgn_in = cres.x[DataW-1];
               sel_hi_in = 1'b1;
               st_in = ST_SX;
            end
         end
         ST_SX, ST_SY: begin
            mul_a = mag_ff[31:0];
            st_in = ST_MAGHI;
         end
         ST_ADD: begin
            acc_in = acc_ff + mul_p[33:0];
            // The first pass handles x and the second y; the top bit of ax_ff
            // tells them apart.
            if (!is_move_ff) begin
               sum = 35'(sgn_ff ? -$signed({1'b0, acc_ff + mul_p[33:0]})
                                :  $signed({1'b0, acc_ff + mul_p[33:0]}));
            end
            if (ax_ff[33] == 1'b0) begin
               sum = sum + 35'(px_ff);
               sat = (sum > 35'sd2147483647) ? 32'sh7FFF_FFFF :
                     (sum < -35'sd2147483648) ? 32'sh8000_0000 : sum[31:0];
               px_in = sat;
               ax_in = {1'b1, 33'd0};
               mag_in = cres.y[DataW-1] ? 34'(-cres.y) : 34'(cres.y);
               sgn_in = cres.y[DataW-1];
               st_in = ST_SY;
            end else begin
               sum = sum + 35'(py_ff);
               sat = (sum > 35'sd2147483647) ? 32'sh7FFF_FFFF :
                     (sum < -35'sd2147483648) ? 32'sh8000_0000 : sum[31:0];
               py_in = sat;
               ax_in = '0;
               st_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp.ready) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         speed_ff <= '0;
         px_ff <= '0; py_ff <= '0; gx_ff <= '0; gy_ff <= '0;
         hd_ff <= '0; act_ff <= 1'b0; ax_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (csr.valid) speed_ff <= csr.move_speed;
         px_ff <= px_in; py_ff <= py_in; gx_ff <= gx_in; gy_ff <= gy_in;
         hd_ff <= hd_in; act_ff <= act_in; ax_ff <= ax_in;
      end
      is_move_ff <= is_move_in; ms_ff <= ms_in; step_ff <= step_in;
      mag_ff <= mag_in; acc_ff <= acc_in; sgn_ff <= sgn_in; sel_hi_ff <= sel_hi_in;
   end

   assign req.ready = (st_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = (st_ff == ST_RESP);
   assign rsp.now_x = px_ff;
   assign rsp.now_y = py_ff;
   assign rsp.heading_out = hd_ff;
   assign rsp.moving = act_ff;

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("request taken with response pending");
   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && (req.kind == KIND_STOP || req.kind == KIND_PLACE))
      |=> !act_ff) else $error("stop or place left block moving");
   a_move_sets: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.kind == KIND_MOVE) |=> act_ff)
      else $error("move did not start motion");

endmodule
